/* src/ste_pkg.sv */
// Shared types, constants and the quarter-wave sine table of the tone generator.
`default_nettype none
package ste_pkg;

   localparam int MAX_CHANNELS    = 8;
   localparam int SINE_TABLE_BITS = 10;
   localparam int PHASE_BITS      = 32;

   localparam int QUARTER_STEPS   = 1 << (SINE_TABLE_BITS - 2);
   localparam int QUARTER_BITS    = SINE_TABLE_BITS - 2;
   localparam int TABLE_ADDR_BITS = QUARTER_BITS + 1;
   localparam int MAG_BITS        = 15;
   localparam int SAMPLE_BITS     = 16;
   localparam int GAIN_BITS       = 16;
   localparam int GAIN_SHIFT      = 15;
   localparam int CHAN_COUNT_BITS = $clog2(MAX_CHANNELS + 1);
   localparam int CHAN_INDEX_BITS = 3;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 32;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_BITS  = 1;

   localparam logic [MAG_BITS-1:0]  SAMPLE_MAX  = 15'd32767;
   localparam logic [63:0]          HALF_PI_Q30 = 64'd1686629713;

   // Register indexes on the csr port
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_INCREMENT = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_VOLUME_GAIN     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CHANNEL_COUNT   = 2'd2;

   // One frame waiting for the channel sequencer
   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0]  sample;
      logic [CHAN_COUNT_BITS-1:0]     chans;
   } frame_type;

   typedef logic [MAG_BITS-1:0] quarter_table_type [QUARTER_STEPS+1];

   // Taylor divisor (2n)(2n+1) of term n
   function automatic logic [63:0] taylor_divisor(input int n);
      case (n)
         1:       return 64'd6;
         2:       return 64'd20;
         3:       return 64'd42;
         4:       return 64'd72;
         5:       return 64'd110;
         6:       return 64'd156;
         default: return 64'd1;
      endcase
   endfunction

   // Restoring long division, used only while building the table
   function automatic logic [63:0] div_u64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[63:0], num[i]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // 32767*sin(k*pi/2/QUARTER_STEPS), Q2.30 series, rounded half up
   function automatic logic [MAG_BITS-1:0] sine_entry(input int k);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] v;
      longint      sum;
      x    = (64'(k) * HALF_PI_Q30) >> QUARTER_BITS;
      x2   = (x * x) >> 30;
      term = x;
      sum  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
         term = div_u64((term * x2) >> 30, taylor_divisor(n));
         if (n[0]) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      v = (64'(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[MAG_BITS-1:0];
   endfunction

   function automatic quarter_table_type build_quarter_table();
      quarter_table_type t;
      for (int k = 0; k <= QUARTER_STEPS; k++) begin
         t[k] = sine_entry(k);
      end
      return t;
   endfunction

   localparam quarter_table_type QUARTER_TABLE = build_quarter_table();

endpackage
`default_nettype wire

/* src/ste_front.sv */
// Front end: phase accumulator, quarter-wave lookup and gain stage.
`default_nettype none
module ste_front (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_tick,
   input  wire logic [ste_pkg::PHASE_BITS-1:0]         phase_increment,
   input  wire logic [ste_pkg::GAIN_BITS-1:0]          volume_gain,
   input  wire logic [ste_pkg::CHAN_COUNT_BITS-1:0]    channel_count,
   output logic                                        push_valid,
   input  wire logic                                   push_full,
   output ste_pkg::frame_type                          push_data
);

   logic [ste_pkg::PHASE_BITS-1:0]       phase_ff, phase_in;
   logic                                 stage_valid_ff, stage_valid_in;
   logic [ste_pkg::MAG_BITS-1:0]         mag_ff;
   logic                                 neg_ff;
   logic [ste_pkg::CHAN_COUNT_BITS-1:0]  chans_ff;

   logic                                   accept;
   logic [ste_pkg::SINE_TABLE_BITS-1:0]    idx;
   logic [ste_pkg::QUARTER_BITS-1:0]       k;
   logic [ste_pkg::TABLE_ADDR_BITS-1:0]    addr;
   logic [ste_pkg::CHAN_COUNT_BITS-1:0]    chans_clamped;
   logic [ste_pkg::MAG_BITS+ste_pkg::GAIN_BITS-1:0] product;
   logic [ste_pkg::MAG_BITS+ste_pkg::GAIN_BITS-ste_pkg::GAIN_SHIFT-1:0] scaled;
   logic [ste_pkg::MAG_BITS-1:0]         sat;

   assign req_ready  = !stage_valid_ff || !push_full;
   assign accept     = req_valid && req_ready;
   assign push_valid = stage_valid_ff;

   // table index and quadrant mirror
   assign idx  = phase_ff[ste_pkg::PHASE_BITS-1 -: ste_pkg::SINE_TABLE_BITS];
   assign k    = idx[ste_pkg::QUARTER_BITS-1:0];
   assign addr = idx[ste_pkg::QUARTER_BITS]
               ? ste_pkg::TABLE_ADDR_BITS'(ste_pkg::QUARTER_STEPS) - {1'b0, k}
               : {1'b0, k};

   always_comb begin
      if (channel_count == '0) begin
         chans_clamped = ste_pkg::CHAN_COUNT_BITS'(1);
      end else if (channel_count > ste_pkg::CHAN_COUNT_BITS'(ste_pkg::MAX_CHANNELS)) begin
         chans_clamped = ste_pkg::CHAN_COUNT_BITS'(ste_pkg::MAX_CHANNELS);
      end else begin
         chans_clamped = channel_count;
      end
   end

   always_comb begin
      phase_in       = phase_ff;
      stage_valid_in = stage_valid_ff;
      if (stage_valid_ff && !push_full) begin
         stage_valid_in = 1'b0;
      end
      if (accept && req_tick) begin
         phase_in       = phase_ff + phase_increment;
         stage_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         stage_valid_ff <= stage_valid_in;
      end
      if (accept && req_tick) begin
         mag_ff   <= ste_pkg::QUARTER_TABLE[addr];
         neg_ff   <= idx[ste_pkg::SINE_TABLE_BITS-1];
         chans_ff <= chans_clamped;
      end
   end

   // gain, truncate, saturate, restore sign
   always_comb begin
      product = {ste_pkg::GAIN_BITS'(0), mag_ff} * {ste_pkg::MAG_BITS'(0), volume_gain};
      scaled  = product[ste_pkg::MAG_BITS+ste_pkg::GAIN_BITS-1:ste_pkg::GAIN_SHIFT];
      if (scaled > {1'b0, ste_pkg::SAMPLE_MAX}) begin
         sat = ste_pkg::SAMPLE_MAX;
      end else begin
         sat = scaled[ste_pkg::MAG_BITS-1:0];
      end
      push_data.chans  = chans_ff;
      push_data.sample = neg_ff ? -$signed({1'b0, sat}) : $signed({1'b0, sat});
   end

endmodule
`default_nettype wire

/* src/ste_queue.sv */
// Two-entry frame queue between front end and channel sequencer.
`default_nettype none
module ste_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push_valid,
   output logic                     push_full,
   input  wire ste_pkg::frame_type  push_data,
   output logic                     pop_valid,
   input  wire logic                pop,
   output ste_pkg::frame_type       pop_data
);

   ste_pkg::frame_type                   mem_ff [ste_pkg::QUEUE_DEPTH];
   logic [ste_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ste_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [ste_pkg::QUEUE_PTR_BITS:0]     count_ff, count_in;
   logic                                 do_push, do_pop;

   assign push_full = (count_ff == (ste_pkg::QUEUE_PTR_BITS+1)'(ste_pkg::QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

/* src/ste_back.sv */
// Back end: copies each frame to its channels through the output register.
`default_nettype none
module ste_back (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                frame_valid,
   input  wire ste_pkg::frame_type                  frame,
   output logic                                     frame_pop,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed [ste_pkg::SAMPLE_BITS-1:0]   rsp_sample_value,
   output logic [ste_pkg::CHAN_INDEX_BITS-1:0]      rsp_channel_index,
   output logic                                     rsp_last_channel
);

   logic [ste_pkg::CHAN_COUNT_BITS-1:0]     chan_ff, chan_in;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic signed [ste_pkg::SAMPLE_BITS-1:0]  sample_ff;
   logic [ste_pkg::CHAN_INDEX_BITS-1:0]     index_ff;
   logic                                    last_ff;
   logic                                    load, is_last;

   assign load      = frame_valid && (!rsp_valid_ff || rsp_ready);
   assign is_last   = (chan_ff + 1'b1) == frame.chans;
   assign frame_pop = load && is_last;

   always_comb begin
      chan_in      = chan_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (load) begin
         rsp_valid_in = 1'b1;
         chan_in      = is_last ? '0 : chan_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         chan_ff      <= chan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (load) begin
         sample_ff <= frame.sample;
         index_ff  <= chan_ff[ste_pkg::CHAN_INDEX_BITS-1:0];
         last_ff   <= is_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_sample_value  = sample_ff;
   assign rsp_channel_index = index_ff;
   assign rsp_last_channel  = last_ff;

endmodule
`default_nettype wire

/* src/sine_tone_generator.sv */
// Top level of the sine tone generator: config registers, front end, queue, back end.
//
// Usage:
//  - req channel: each accepted item with req_tick high asks for one frame;
//    an item with req_tick low is taken and produces nothing.
//  - rsp channel: a frame comes out as channel_count items (0 acts as 1,
//    above 8 acts as 8), channel_index counting from 0, last_channel set on
//    the final one. Every item of a frame carries the same sample.
//  - csr port: write-only; index 0 phase_increment, 1 volume_gain,
//    2 channel_count, index 3 is ignored. Write only while the block is idle.
//  - Path: a taken req item passes the lookup register, the frame queue
//    and the output register before rsp_valid rises.
//  - Throughput: one rsp item per cycle while rsp_ready is high; a new
//    tick can be taken every cycle while the frame queue has room.
//    The channel sequencer's output register sets the rate.
//  - Receiver stall: rsp items hold; the queue takes two frames and the
//    lookup register a third, then req_ready drops until the sequencer
//    frees a queue entry.
//  - Reset: phase 0, increment 0, gain 1.0 (32768), one channel, queue empty.
`default_nettype none
module sine_tone_generator (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic                                  req_tick,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic signed [ste_pkg::SAMPLE_BITS-1:0]     rsp_sample_value,
   output logic [ste_pkg::CHAN_INDEX_BITS-1:0]        rsp_channel_index,
   output logic                                       rsp_last_channel,
   input  wire logic                                  csr_write_enable,
   input  wire logic [ste_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [ste_pkg::CSR_DATA_BITS-1:0]     csr_write_data
);

   // config registers
   logic [ste_pkg::PHASE_BITS-1:0]       phase_increment_ff;
   logic [ste_pkg::GAIN_BITS-1:0]        volume_gain_ff;
   logic [ste_pkg::CHAN_COUNT_BITS-1:0]  channel_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_increment_ff <= '0;
         volume_gain_ff     <= ste_pkg::GAIN_BITS'(32768);
         channel_count_ff   <= ste_pkg::CHAN_COUNT_BITS'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            ste_pkg::CSR_PHASE_INCREMENT: begin
               phase_increment_ff <= csr_write_data[ste_pkg::PHASE_BITS-1:0];
            end
            ste_pkg::CSR_VOLUME_GAIN: begin
               volume_gain_ff <= csr_write_data[ste_pkg::GAIN_BITS-1:0];
            end
            ste_pkg::CSR_CHANNEL_COUNT: begin
               channel_count_ff <= csr_write_data[ste_pkg::CHAN_COUNT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // front end -> queue
   logic                  push_valid;
   logic                  push_full;
   ste_pkg::frame_type    push_data;

   // queue -> back end
   logic                  frame_valid;
   logic                  frame_pop;
   ste_pkg::frame_type    frame;

   ste_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_tick        (req_tick),
      .phase_increment (phase_increment_ff),
      .volume_gain     (volume_gain_ff),
      .channel_count   (channel_count_ff),
      .push_valid      (push_valid),
      .push_full       (push_full),
      .push_data       (push_data)
   );

   ste_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_data  (push_data),
      .pop_valid  (frame_valid),
      .pop        (frame_pop),
      .pop_data   (frame)
   );

   ste_back u_back (
      .clock             (clock),
      .reset             (reset),
      .frame_valid       (frame_valid),
      .frame             (frame),
      .frame_pop         (frame_pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_sample_value  (rsp_sample_value),
      .rsp_channel_index (rsp_channel_index),
      .rsp_last_channel  (rsp_last_channel)
   );

endmodule
`default_nettype wire
